// ===== hw/rtl/swr_pkg.sv =====
// Package for the sliding-window receiver: widths, codes and the shared
// command and result types. Depends on nothing.
package swr_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SEQ_W      = 16;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int IDLE_W     = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Command queue between front and back
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = 2;
    localparam int CMD_CNT_W  = 3;

    // Result queue at the output
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = 1;
    localparam int RES_CNT_W  = 2;

    // Item kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_FIN  = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 1'b1;

    localparam logic [CNT_W-1:0]  WINDOW_RESET = 7'd8;
    localparam logic [IDLE_W-1:0] IDLE_RESET   = 20'd10000;

    // Classified request, as the back end needs it
    typedef struct packed {
        logic              is_data;
        logic              is_fin;
        logic              is_idle;
        logic              seq_hi_zero;
        logic [SLOT_W-1:0] seq_lo;
        logic              more;
        logic              crc_ok;
        logic              fin_ack;
    } t_cmd;

    typedef struct packed {
        logic              store_valid;
        logic [SLOT_W-1:0] store_slot;
        logic              flush_valid;
        logic [CNT_W-1:0]  flush_count;
        logic              ack_valid;
        logic [SLOT_W-1:0] ack_seq;
        logic              fin_valid;
        logic              final_ack_valid;
        logic              done_ok;
        logic              timed_out;
    } t_result;

endpackage

// ===== hw/rtl/sliding_window_receiver.sv =====
// Top level of the sliding-window (go-back-N) receiver control block:
// configuration registers and the front/back split. Depends on swr_pkg,
// swr_front and swr_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  request  | push / full            | kind, seq_num, more_fragments, crc_ok,
//           |                        | is_fin_ack
//  result   | empty / pop            | store, flush, ack, fin, final ack, done,
//           |                        | timeout fields
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (window_size, idle_limit)
//
// One request per cycle sustained while results are popped; every request yields
// exactly one result. A taken request waits in the command queue and is stepped
// into the result queue when it has room; the result is on the ports at its head.
// Reset is synchronous and active low: register defaults, both queues empty.
// With pop held low the two-entry result queue fills, then the four-entry
// command queue, and only then does full rise. cfg_ready is tied high.
module sliding_window_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_kind,
    input  logic [swr_pkg::SEQ_W-1:0]      i_seq_num,
    input  logic                           i_more_fragments,
    input  logic                           i_crc_ok,
    input  logic                           i_is_fin_ack,
    // result channel
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_store_valid,
    output logic [swr_pkg::SLOT_W-1:0]     o_store_slot,
    output logic                           o_flush_valid,
    output logic [swr_pkg::CNT_W-1:0]      o_flush_count,
    output logic                           o_ack_valid,
    output logic [swr_pkg::SLOT_W-1:0]     o_ack_seq,
    output logic                           o_fin_valid,
    output logic                           o_final_ack_valid,
    output logic                           o_done_ok,
    output logic                           o_timed_out,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [swr_pkg::CNT_W-1:0]  r_window_size;
    logic [swr_pkg::IDLE_W-1:0] r_idle_limit;
    logic [swr_pkg::CNT_W-1:0]  eff_window;
    logic [swr_pkg::IDLE_W-1:0] eff_limit;
    logic                       cmd_valid;
    logic                       cmd_pop;
    swr_pkg::t_cmd              cmd;
    swr_pkg::t_result           res;

    assign o_cfg_ready = 1'b1;

    // Hold the configuration registers; write on a completed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swr_pkg::WINDOW_RESET;
            r_idle_limit  <= swr_pkg::IDLE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swr_pkg::CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[swr_pkg::CNT_W-1:0];
                swr_pkg::CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the window to 2..MAX_WINDOW; a zero idle limit acts as one
    always_comb begin
        if (r_window_size < swr_pkg::CNT_W'(2)) begin
            eff_window = swr_pkg::CNT_W'(2);
        end else if (r_window_size > swr_pkg::CNT_W'(swr_pkg::MAX_WINDOW)) begin
            eff_window = swr_pkg::CNT_W'(swr_pkg::MAX_WINDOW);
        end else begin
            eff_window = r_window_size;
        end
        eff_limit = (r_idle_limit == '0) ? swr_pkg::IDLE_W'(1) : r_idle_limit;
    end

    swr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_seq_num        (i_seq_num),
        .i_more_fragments (i_more_fragments),
        .i_crc_ok         (i_crc_ok),
        .i_is_fin_ack     (i_is_fin_ack),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    swr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (eff_window),
        .i_limit     (eff_limit),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res)
    );

    assign o_store_valid     = res.store_valid;
    assign o_store_slot      = res.store_slot;
    assign o_flush_valid     = res.flush_valid;
    assign o_flush_count     = res.flush_count;
    assign o_ack_valid       = res.ack_valid;
    assign o_ack_seq         = res.ack_seq;
    assign o_fin_valid       = res.fin_valid;
    assign o_final_ack_valid = res.final_ack_valid;
    assign o_done_ok         = res.done_ok;
    assign o_timed_out       = res.timed_out;

endmodule

// ===== hw/rtl/swr_front.sv =====
// Front end of the sliding-window receiver: classifies incoming requests
// and holds them in a short command queue. Depends on swr_pkg.
module swr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_kind,
    input  logic [swr_pkg::SEQ_W-1:0] i_seq_num,
    input  logic                      i_more_fragments,
    input  logic                      i_crc_ok,
    input  logic                      i_is_fin_ack,
    output logic                      o_cmd_valid,
    output swr_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_pop
);

    swr_pkg::t_cmd                    r_q [swr_pkg::CMD_DEPTH];
    logic [swr_pkg::CMD_PTR_W-1:0]    r_wr_ptr;
    logic [swr_pkg::CMD_PTR_W-1:0]    r_rd_ptr;
    logic [swr_pkg::CMD_CNT_W-1:0]    r_cnt;
    swr_pkg::t_cmd                    cmd_in;
    logic                             wr_en;
    logic                             rd_en;

    // Classify the request
    always_comb begin
        cmd_in             = '0;
        cmd_in.is_data     = (i_kind == swr_pkg::KIND_DATA);
        cmd_in.is_fin      = (i_kind == swr_pkg::KIND_FIN);
        cmd_in.is_idle     = (i_kind == swr_pkg::KIND_IDLE);
        cmd_in.seq_hi_zero = (i_seq_num[swr_pkg::SEQ_W-1:swr_pkg::SLOT_W] == '0);
        cmd_in.seq_lo      = i_seq_num[swr_pkg::SLOT_W-1:0];
        cmd_in.more        = i_more_fragments;
        cmd_in.crc_ok      = i_crc_ok;
        cmd_in.fin_ack     = i_is_fin_ack;
    end

    assign full        = (r_cnt == swr_pkg::CMD_CNT_W'(swr_pkg::CMD_DEPTH));
    assign wr_en       = push & ~full;
    assign o_cmd_valid = (r_cnt != '0);
    assign rd_en       = i_cmd_pop & o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/swr_back.sv =====
// Back end of the sliding-window receiver: protocol state, one request per
// cycle while the output has room, and the result queue. Depends on swr_pkg.
module swr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [swr_pkg::CNT_W-1:0]  i_window,
    input  logic [swr_pkg::IDLE_W-1:0] i_limit,
    input  logic                       i_cmd_valid,
    input  swr_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       empty,
    input  logic                       pop,
    output swr_pkg::t_result           o_res
);

    localparam int MOD_W = swr_pkg::CNT_W + swr_pkg::SLOT_W;

    logic [swr_pkg::SLOT_W-1:0]  r_exp;
    logic [swr_pkg::CNT_W-1:0]   r_pkt_cnt;
    logic                        r_end_seen;
    logic                        r_fin_sent;
    logic                        r_finished;
    logic [swr_pkg::IDLE_W-1:0]  r_idle_cnt;

    logic [swr_pkg::SLOT_W-1:0]  n_exp;
    logic [swr_pkg::CNT_W-1:0]   n_pkt_cnt;
    logic                        n_end_seen;
    logic                        n_fin_sent;
    logic                        n_finished;
    logic [swr_pkg::IDLE_W-1:0]  n_idle_cnt;

    swr_pkg::t_result            res;
    swr_pkg::t_result            r_rq [swr_pkg::RES_DEPTH];
    logic [swr_pkg::RES_PTR_W-1:0] r_wr_ptr;
    logic [swr_pkg::RES_PTR_W-1:0] r_rd_ptr;
    logic [swr_pkg::RES_CNT_W-1:0] r_cnt;

    logic [swr_pkg::CNT_W-1:0]   next_seq;
    logic [swr_pkg::CNT_W-1:0]   next_mod;
    logic [MOD_W-1:0]            mod_sub;
    logic [swr_pkg::CNT_W-1:0]   pkt_inc;
    logic [swr_pkg::IDLE_W-1:0]  idle_inc;
    logic                        in_order;
    logic                        end_new;
    logic                        out_space;
    logic                        go;
    logic                        rd_en;

    assign empty     = (r_cnt == '0);
    assign rd_en     = pop & ~empty;
    assign out_space = (r_cnt != swr_pkg::RES_CNT_W'(swr_pkg::RES_DEPTH)) | rd_en;
    assign go        = i_cmd_valid & out_space;
    assign o_cmd_pop = go;
    assign o_res     = r_rq[r_rd_ptr];

    assign next_seq = {1'b0, r_exp} + 1'b1;
    assign pkt_inc  = r_pkt_cnt + 1'b1;
    assign idle_inc = (r_idle_cnt != '1) ? r_idle_cnt + 1'b1 : r_idle_cnt;
    assign in_order = i_cmd.is_data & i_cmd.seq_hi_zero & (i_cmd.seq_lo == r_exp)
                    & i_cmd.crc_ok;
    assign end_new  = r_end_seen | (in_order & ~i_cmd.more);

    // Reduce the next expected number modulo the window by shifted subtracts
    always_comb begin
        next_mod = next_seq;
        for (int k = swr_pkg::SLOT_W - 1; k >= 0; k--) begin
            mod_sub = MOD_W'(i_window) << k;
            if (MOD_W'(next_mod) >= mod_sub) begin
                next_mod = swr_pkg::CNT_W'(MOD_W'(next_mod) - mod_sub);
            end
        end
    end

    always_comb begin
        n_exp      = r_exp;
        n_pkt_cnt  = r_pkt_cnt;
        n_end_seen = r_end_seen;
        n_fin_sent = r_fin_sent;
        n_finished = r_finished;
        n_idle_cnt = r_idle_cnt;
        res        = '0;
        if (!r_finished) begin
            if (i_cmd.is_data) begin
                n_idle_cnt = '0;
                n_pkt_cnt  = pkt_inc;
                if (in_order) begin
                    res.store_valid = 1'b1;
                    res.store_slot  = r_exp;
                    if ((!i_cmd.more || next_seq >= i_window) && !r_fin_sent) begin
                        res.flush_valid = 1'b1;
                        res.flush_count = next_seq;
                    end
                    n_exp      = next_mod[swr_pkg::SLOT_W-1:0];
                    n_end_seen = end_new;
                end
                if (pkt_inc == (i_window - 1'b1) || end_new) begin
                    res.ack_valid = 1'b1;
                    res.ack_seq   = n_exp;
                    n_pkt_cnt     = '0;
                end
                if (end_new && !r_fin_sent) begin
                    n_fin_sent    = 1'b1;
                    res.fin_valid = 1'b1;
                end
            end else if (i_cmd.is_fin) begin
                n_idle_cnt = '0;
                if (i_cmd.fin_ack) begin
                    res.final_ack_valid = 1'b1;
                    res.done_ok         = 1'b1;
                    n_finished          = 1'b1;
                end
            end else if (i_cmd.is_idle) begin
                n_idle_cnt = idle_inc;
                if (idle_inc >= i_limit) begin
                    res.timed_out = 1'b1;
                    n_finished    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rq[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp      <= '0;
            r_pkt_cnt  <= '0;
            r_end_seen <= 1'b0;
            r_fin_sent <= 1'b0;
            r_finished <= 1'b0;
            r_idle_cnt <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_cnt      <= '0;
        end else begin
            if (go) begin
                r_exp      <= n_exp;
                r_pkt_cnt  <= n_pkt_cnt;
                r_end_seen <= n_end_seen;
                r_fin_sent <= n_fin_sent;
                r_finished <= n_finished;
                r_idle_cnt <= n_idle_cnt;
                r_wr_ptr   <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({go, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== test/sliding_window_receiver_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_receiver: a clocked driver and monitor,
// plus a transaction-level predictor of the go-back-N receiver control.
// Depends on swr_pkg and the sliding_window_receiver RTL.
module sliding_window_receiver_test;

    // Kind 3 is unused by the block and must leave no trace in the state
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [swr_pkg::CNT_W-1:0] WIN_FLOOR = swr_pkg::CNT_W'(2);
    localparam logic [swr_pkg::CNT_W-1:0] WIN_CAP   = swr_pkg::CNT_W'(swr_pkg::MAX_WINDOW);

    localparam int SETTLE_CYCLES = 4;      // drain margin used by wait_settled
    localparam int LONG_HOLD     = 80;     // receiver hold-off, long enough to fill both queues
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic [swr_pkg::CNT_W-1:0]  win;        // window_size register as written
        logic [swr_pkg::IDLE_W-1:0] idle_lim;   // idle_limit register as written
        logic [swr_pkg::SLOT_W-1:0] exp_seq;
        logic [swr_pkg::CNT_W-1:0]  pkt_cnt;    // data packets since the last ack
        logic                       end_seen;
        logic                       fin_sent;
        logic                       finished;
        logic [swr_pkg::IDLE_W-1:0] idle_cnt;
    } t_rx_state;

    typedef struct {
        logic [1:0]                kind;
        logic [swr_pkg::SEQ_W-1:0] seq;
        logic                      more;
        logic                      crc_ok;
        logic                      fin_ack;
    } t_header;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [1:0]                     i_kind = '0;
    logic [swr_pkg::SEQ_W-1:0]      i_seq_num = '0;
    logic                           i_more_fragments = 1'b0;
    logic                           i_crc_ok = 1'b0;
    logic                           i_is_fin_ack = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_store_valid;
    logic [swr_pkg::SLOT_W-1:0]     o_store_slot;
    logic                           o_flush_valid;
    logic [swr_pkg::CNT_W-1:0]      o_flush_count;
    logic                           o_ack_valid;
    logic [swr_pkg::SLOT_W-1:0]     o_ack_seq;
    logic                           o_fin_valid;
    logic                           o_final_ack_valid;
    logic                           o_done_ok;
    logic                           o_timed_out;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [swr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [swr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Two copies of the receiver state: plan_rx runs ahead as headers are queued so
    // the generator knows the next in-order number, live_rx advances on acceptance.
    t_rx_state live_rx;
    t_rx_state plan_rx;

    t_header          headers_waiting[$];   // requests not yet offered to the block
    swr_pkg::t_result results_due[$];       // predicted results, oldest first
    t_header          offered;
    swr_pkg::t_result popped;

    int  failures = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  drain_hold = 0;
    int  holds_asked = 0;
    int  holds_served = 0;
    bit  calm = 1'b0;              // no idling on either side while set

    sliding_window_receiver i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_kind            (i_kind),
        .i_seq_num         (i_seq_num),
        .i_more_fragments  (i_more_fragments),
        .i_crc_ok          (i_crc_ok),
        .i_is_fin_ack      (i_is_fin_ack),
        .empty             (empty),
        .pop               (pop),
        .o_store_valid     (o_store_valid),
        .o_store_slot      (o_store_slot),
        .o_flush_valid     (o_flush_valid),
        .o_flush_count     (o_flush_count),
        .o_ack_valid       (o_ack_valid),
        .o_ack_seq         (o_ack_seq),
        .o_fin_valid       (o_fin_valid),
        .o_final_ack_valid (o_final_ack_valid),
        .o_done_ok         (o_done_ok),
        .o_timed_out       (o_timed_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the receiver by one request and return the result it causes.
    function automatic swr_pkg::t_result rx_advance(inout t_rx_state s, input t_header h);
        swr_pkg::t_result           r;
        logic [swr_pkg::CNT_W-1:0]  ws;
        logic [swr_pkg::CNT_W-1:0]  nxt;
        logic [swr_pkg::IDLE_W-1:0] lim;
        r = '0;
        // out-of-range window sizes clamp, a zero idle limit acts as one
        ws  = (s.win < WIN_FLOOR) ? WIN_FLOOR : (s.win > WIN_CAP) ? WIN_CAP : s.win;
        lim = (s.idle_lim == '0) ? swr_pkg::IDLE_W'(1) : s.idle_lim;
        if (s.finished)
            return r;
        case (h.kind)
            swr_pkg::KIND_DATA: begin
                s.idle_cnt = '0;
                s.pkt_cnt  = s.pkt_cnt + 1'b1;   // wraps at 128 after a window shrink
                if (h.seq == {{(swr_pkg::SEQ_W-swr_pkg::SLOT_W){1'b0}}, s.exp_seq}
                    && h.crc_ok) begin
                    nxt           = {1'b0, s.exp_seq} + 1'b1;
                    r.store_valid = 1'b1;
                    r.store_slot  = s.exp_seq;
                    if ((!h.more || nxt >= ws) && !s.fin_sent) begin
                        r.flush_valid = 1'b1;
                        r.flush_count = nxt;
                    end
                    // only reduce modulo the window when the next number reaches the window
                    if (nxt >= ws)
                        nxt = nxt % ws;
                    s.exp_seq = nxt[swr_pkg::SLOT_W-1:0];
                    if (!h.more)
                        s.end_seen = 1'b1;
                end
                if (s.pkt_cnt == ws - 1'b1 || s.end_seen) begin
                    r.ack_valid = 1'b1;
                    r.ack_seq   = s.exp_seq;
                    s.pkt_cnt   = '0;
                end
                if (s.end_seen && !s.fin_sent) begin
                    s.fin_sent  = 1'b1;
                    r.fin_valid = 1'b1;
                end
            end
            swr_pkg::KIND_FIN: begin
                // a plain fin only restarts the idle count
                s.idle_cnt = '0;
                if (h.fin_ack) begin
                    r.final_ack_valid = 1'b1;
                    r.done_ok         = 1'b1;
                    s.finished        = 1'b1;
                end
            end
            swr_pkg::KIND_IDLE: begin
                if (s.idle_cnt != '1)
                    s.idle_cnt = s.idle_cnt + 1'b1;
                if (s.idle_cnt >= lim) begin
                    r.timed_out = 1'b1;
                    s.finished  = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic cmp_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic check_result(input swr_pkg::t_result want, input swr_pkg::t_result got);
        cmp_field("store_valid", 8'(want.store_valid), 8'(got.store_valid));
        cmp_field("store_slot", 8'(want.store_slot), 8'(got.store_slot));
        cmp_field("flush_valid", 8'(want.flush_valid), 8'(got.flush_valid));
        cmp_field("flush_count", 8'(want.flush_count), 8'(got.flush_count));
        cmp_field("ack_valid", 8'(want.ack_valid), 8'(got.ack_valid));
        cmp_field("ack_seq", 8'(want.ack_seq), 8'(got.ack_seq));
        cmp_field("fin_valid", 8'(want.fin_valid), 8'(got.fin_valid));
        cmp_field("final_ack_valid", 8'(want.final_ack_valid), 8'(got.final_ack_valid));
        cmp_field("done_ok", 8'(want.done_ok), 8'(got.done_ok));
        cmp_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
    endtask

    // Driver: hold a stalled request, otherwise idle for a burst or offer the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else begin
            if (push && !full)
                results_due.push_back(rx_advance(live_rx, offered));
            if (push && full) begin
                // hold: the block has not taken the request yet
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(1, 18) - 1;
                push <= 1'b0;
            end else if (headers_waiting.size() != 0) begin
                offered = headers_waiting.pop_front();
                i_kind           <= offered.kind;
                i_seq_num        <= offered.seq;
                i_more_fragments <= offered.more;
                i_crc_ok         <= offered.crc_ok;
                i_is_fin_ack     <= offered.fin_ack;
                push             <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check every popped result, stall in bursts or for a requested long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            drain_hold = 0;
        end else begin
            if (pop && !empty) begin
                popped = {o_store_valid, o_store_slot, o_flush_valid, o_flush_count,
                          o_ack_valid, o_ack_seq, o_fin_valid, o_final_ack_valid,
                          o_done_ok, o_timed_out};
                if (results_due.size() == 0) begin
                    failures++;
                    $display("%0t: result popped with none expected, got %h", $time, popped);
                end else begin
                    check_result(results_due.pop_front(), popped);
                end
            end
            if (drain_hold > 0) begin
                drain_hold--;
                pop <= 1'b0;
            end else if (holds_served != holds_asked) begin
                holds_served++;
                drain_hold = LONG_HOLD - 1;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                drain_hold = $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [swr_pkg::SEQ_W-1:0] in_order_seq();
        return {{(swr_pkg::SEQ_W-swr_pkg::SLOT_W){1'b0}}, plan_rx.exp_seq};
    endfunction

    task automatic queue_header(input logic [1:0] kind, input logic [swr_pkg::SEQ_W-1:0] seq,
                                input logic more, input logic crc_ok, input logic fin_ack);
        t_header          h;
        swr_pkg::t_result discard;
        h.kind    = kind;
        h.seq     = seq;
        h.more    = more;
        h.crc_ok  = crc_ok;
        h.fin_ack = fin_ack;
        discard   = rx_advance(plan_rx, h);
        headers_waiting.push_back(h);
    endtask

    // Mostly in-order good packets; the rest broken packets, fins, idle runs and noise.
    // Before the last packet is wanted, an accepted packet never carries more=0, and
    // idle runs always stop one tick short of the limit.
    task automatic queue_random(input int n, input bit after_end);
        int                         pick;
        int                         run;
        int                         k;
        logic [swr_pkg::SEQ_W-1:0]  seq;
        logic                       more;
        logic                       crc;
        logic                       fa;
        logic [swr_pkg::IDLE_W-1:0] lim;
        k = 0;
        while (k < n) begin
            pick = $urandom_range(0, 99);
            seq  = swr_pkg::SEQ_W'($urandom_range(0, 65535));
            more = 1'($urandom_range(0, 1));
            crc  = 1'($urandom_range(0, 1));
            fa   = 1'($urandom_range(0, 1));
            lim  = (plan_rx.idle_lim == '0) ? swr_pkg::IDLE_W'(1) : plan_rx.idle_lim;
            if (pick < 62) begin
                queue_header(swr_pkg::KIND_DATA, in_order_seq(), after_end ? more : 1'b1,
                             1'b1, fa);
                k++;
            end else if (pick < 76) begin
                case ($urandom_range(0, 2))
                    0: ;
                    1: seq[swr_pkg::SLOT_W-1:0] = plan_rx.exp_seq;   // right low bits only
                    default: seq = in_order_seq() + 1'b1;           // one past the expected number
                endcase
                if (!after_end && seq == in_order_seq() && crc)
                    more = 1'b1;
                queue_header(swr_pkg::KIND_DATA, seq, more, crc, fa);
                k++;
            end else if (pick < 84) begin
                queue_header(swr_pkg::KIND_FIN, seq, more, crc, 1'b0);
                k++;
            end else if (pick < 97) begin
                run = $urandom_range(1, 8);
                while (run > 0 && k < n && plan_rx.idle_cnt + 1 < lim) begin
                    queue_header(swr_pkg::KIND_IDLE, seq, more, crc, fa);
                    k++;
                    run--;
                end
            end else begin
                queue_header(KIND_UNUSED, seq, more, crc, fa);
            end
        end
    endtask

    // Write one register with the block idle, and mirror it in both state copies.
    task automatic write_reg(input logic [swr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swr_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == swr_pkg::CFG_WINDOW_SIZE) begin
            live_rx.win = val[swr_pkg::CNT_W-1:0];
            plan_rx.win = val[swr_pkg::CNT_W-1:0];
        end else begin
            live_rx.idle_lim = val[swr_pkg::IDLE_W-1:0];
            plan_rx.idle_lim = val[swr_pkg::IDLE_W-1:0];
        end
    endtask

    // Wait until every request is taken and every result checked, then let the pipe drain.
    task automatic wait_settled();
        do
            @(negedge i_clk);
        while (headers_waiting.size() != 0 || push || results_due.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge i_clk);
    endtask

    initial begin
        int win_plan[9]  = '{2, 0, 64, 127, 1, 65, 3, 0, 64};
        int idle_plan[9] = '{1, 0, 3, 20'hFFFFF, 2, 37, 5, 0, 10000};
        int i;
        int p;

        live_rx = '{win: swr_pkg::WINDOW_RESET, idle_lim: swr_pkg::IDLE_RESET, exp_seq: '0,
                    pkt_cnt: '0, end_seen: 1'b0, fin_sent: 1'b0, finished: 1'b0,
                    idle_cnt: '0};
        plan_rx = live_rx;
        win_plan[7]  = $urandom_range(2, 64);
        idle_plan[7] = $urandom_range(1, 40);

        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset configuration (window 8)
        queue_header(swr_pkg::KIND_DATA, 16'd0, 1'b1, 1'b1, 1'b0);            // first slot
        queue_header(swr_pkg::KIND_DATA, 16'd1, 1'b0, 1'b0, 1'b1);            // last, bad CRC
        queue_header(swr_pkg::KIND_DATA, 16'hFFFF, 1'b0, 1'b1, 1'b0);         // all ones
        queue_header(swr_pkg::KIND_DATA, {10'h3FF, 6'd1}, 1'b0, 1'b1, 1'b1);  // low bits only
        queue_header(KIND_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1'b1);                // unused kind
        queue_header(swr_pkg::KIND_FIN, 16'hA5A5, 1'b1, 1'b1, 1'b0);          // plain fin
        queue_header(swr_pkg::KIND_IDLE, 16'h5A5A, 1'b0, 1'b0, 1'b1);
        // fill the window: ack at window-1 packets, flush when it wraps
        for (i = 0; i < 7; i++)
            queue_header(swr_pkg::KIND_DATA, in_order_seq(), 1'b1, 1'b1, 1'b0);
        queue_header(swr_pkg::KIND_DATA, in_order_seq(), 1'b1, 1'b0, 1'b0);    // bad CRC
        queue_header(swr_pkg::KIND_DATA, in_order_seq() + 16'd2, 1'b1, 1'b1, 1'b0);
        queue_header(swr_pkg::KIND_IDLE, 16'd0, 1'b0, 1'b0, 1'b0);
        queue_header(swr_pkg::KIND_IDLE, 16'd0, 1'b1, 1'b1, 1'b1);
        queue_header(swr_pkg::KIND_FIN, 16'd0, 1'b0, 1'b0, 1'b0);
        queue_header(swr_pkg::KIND_DATA, in_order_seq(), 1'b1, 1'b1, 1'b0);

        // Random phases across window sizes and idle limits, extremes included
        for (p = 0; p < 9; p++) begin
            wait_settled();
            write_reg(swr_pkg::CFG_WINDOW_SIZE, swr_pkg::CFG_DATA_W'(win_plan[p]));
            write_reg(swr_pkg::CFG_IDLE_LIMIT, swr_pkg::CFG_DATA_W'(idle_plan[p]));
            calm = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                calm = 1'b0;
                holds_asked++;   // receiver stalls long enough to back the block up
            end
            queue_random(110, 1'b0);
        end

        // Last part: mark end of file, then acks on every packet, no idling
        wait_settled();
        write_reg(swr_pkg::CFG_WINDOW_SIZE, swr_pkg::CFG_DATA_W'($urandom_range(2, 64)));
        write_reg(swr_pkg::CFG_IDLE_LIMIT, swr_pkg::CFG_DATA_W'(1000));
        calm = 1'b1;
        queue_header(swr_pkg::KIND_DATA, in_order_seq(), 1'b0, 1'b1, 1'b0);
        queue_random(150, 1'b1);

        // Finish the transfer either by fin-ack or by running out the idle limit
        if ($urandom_range(0, 1) == 1) begin
            queue_header(swr_pkg::KIND_FIN, swr_pkg::SEQ_W'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            wait_settled();
            write_reg(swr_pkg::CFG_IDLE_LIMIT, swr_pkg::CFG_DATA_W'($urandom_range(1, 6)));
            while (!plan_rx.finished)
                queue_header(swr_pkg::KIND_IDLE, swr_pkg::SEQ_W'($urandom_range(0, 65535)),
                             1'b0, 1'b0, 1'b0);
        end
        // Everything after the end must be ignored
        for (i = 0; i < 8; i++)
            queue_header(2'(i % 4), swr_pkg::SEQ_W'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'b1, 1'b1);

        wait_settled();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
